// ----- rtl/core/numeric_literal_scanner_assert.svh -----
// Assertion macros for the numeric literal scanner.
// Included by modules that check their own logic; no other dependencies.
`ifndef NUMERIC_LITERAL_SCANNER_ASSERT_SVH
`define NUMERIC_LITERAL_SCANNER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define NLS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define NLS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NLS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define NLS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- rtl/core/nls_pkg.sv -----
// Shared types, character codes and the character classifier of the
// numeric literal scanner. No dependencies.
package nls_pkg;

    // Interpretation phase codes.
    typedef logic [2:0] phase_t;
    localparam phase_t PH_DEAD  = 3'd0;
    localparam phase_t PH_FIRST = 3'd1;
    localparam phase_t PH_RUN   = 3'd2;
    localparam phase_t PH_DONE  = 3'd3;
    localparam phase_t PH_ZERO  = 3'd4;

    // Interpretation slots.
    localparam int I_BIN = 0;
    localparam int I_OCT = 1;
    localparam int I_DEC = 2;
    localparam int I_HEX = 3;

    // Digit class codes: 0 to 15 are digit values.
    typedef logic [4:0] dclass_t;
    localparam dclass_t SEP_CODE   = 5'd16;
    localparam dclass_t OTHER_CODE = 5'd17;

    // Character codes.
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_B = 8'h42;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_H = 8'h48;
    localparam logic [7:0] CH_UPPER_O = 8'h4F;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // Control part of the scan state.
    typedef struct packed {
        logic             active;
        logic             neg;
        logic             hex_pfx;
        phase_t [3:0]     phase;
    } scan_ctl_t;

    // One result word.
    typedef struct packed {
        logic signed [31:0] value;
        logic [6:0]         length;
        logic               found;
        logic               too_long;
    } res_t;

    // Maps a character to its digit value, the separator code or the other code.
    function automatic dclass_t classify(input logic [7:0] c);
        dclass_t r;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = 5'(c - CH_ZERO);
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            r = 5'(c - CH_UPPER_A + 8'd10);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            r = 5'(c - CH_LOWER_A + 8'd10);
        end else if (c == CH_UNDER) begin
            r = SEP_CODE;
        end else begin
            r = OTHER_CODE;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/nls_step.sv -----
// Next-state and result logic for one character of the numeric literal scanner.
// Purely combinational; depends on nls_pkg.
module nls_step #(
    parameter int MAX_LEN = 64,
    parameter int POS_W   = 7
) (
    input  logic [7:0]                ch,
    input  logic                      start_req,
    input  nls_pkg::scan_ctl_t        ctl,
    input  logic [POS_W-1:0]          pos,
    input  logic [3:0][POS_W-1:0]     len,
    input  logic [3:0][31:0]          val,
    output nls_pkg::scan_ctl_t        ctl_next,
    output logic [POS_W-1:0]          pos_next,
    output logic [3:0][POS_W-1:0]     len_next,
    output logic [3:0][31:0]          val_next,
    output logic                      emit,
    output nls_pkg::res_t             res
);

    nls_pkg::scan_ctl_t       b_ctl;
    logic [POS_W-1:0]         b_pos;
    logic [3:0][POS_W-1:0]    b_len;
    logic [3:0][31:0]         b_val;
    logic                     is_sign;

    nls_pkg::scan_ctl_t       stp_ctl;
    logic [3:0][POS_W-1:0]    stp_len;
    logic [3:0][31:0]         stp_val;
    logic [3:0]               used_vec;
    logic                     used;
    logic                     last;
    logic [POS_W-1:0]         pos_inc;
    nls_pkg::dclass_t         d;

    logic [3:0][POS_W-1:0]    elen;
    logic [3:0]               best;
    logic [POS_W-1:0]         win_len;
    logic [31:0]              win_val;
    logic                     found;

    // A start request clears the scan and arms all four interpretations.
    always_comb begin
        is_sign = start_req && (ch == nls_pkg::CH_MINUS || ch == nls_pkg::CH_PLUS);
        if (start_req) begin
            b_ctl        = '0;
            b_ctl.active = 1'b1;
            for (int k = 0; k < 4; k++) begin
                b_ctl.phase[k] = nls_pkg::PH_FIRST;
            end
            b_pos = '0;
            b_len = '0;
            b_val = '0;
        end else begin
            b_ctl = ctl;
            b_pos = pos;
            b_len = len;
            b_val = val;
        end
    end

    // Advance the four interpretations by one character.
    always_comb begin
        nls_pkg::phase_t ph;
        nls_pkg::dclass_t top;
        logic [7:0] sfx;
        d        = nls_pkg::classify(ch);
        pos_inc  = b_pos + 1'b1;
        stp_ctl  = b_ctl;
        stp_len  = b_len;
        stp_val  = b_val;
        used_vec = '0;

        // Binary and octal runs, closed by their suffix letter.
        for (int k = 0; k < 2; k++) begin
            ph  = b_ctl.phase[k];
            top = (k == nls_pkg::I_BIN) ? 5'd1 : 5'd7;
            sfx = (k == nls_pkg::I_BIN) ? nls_pkg::CH_UPPER_B : nls_pkg::CH_UPPER_O;
            if (ph == nls_pkg::PH_FIRST || ph == nls_pkg::PH_RUN) begin
                if (d <= top || d == nls_pkg::SEP_CODE) begin
                    if (d <= top) begin
                        stp_val[k] = (k == nls_pkg::I_BIN) ? {b_val[k][30:0], d[0]}
                                                           : {b_val[k][28:0], d[2:0]};
                    end
                    stp_ctl.phase[k] = nls_pkg::PH_RUN;
                    used_vec[k]      = 1'b1;
                end else if (ph == nls_pkg::PH_RUN
                             && (ch == sfx || ch == (sfx | nls_pkg::CASE_BIT))) begin
                    stp_ctl.phase[k] = nls_pkg::PH_DONE;
                    stp_len[k]       = pos_inc;
                    used_vec[k]      = 1'b1;
                end else begin
                    stp_ctl.phase[k] = nls_pkg::PH_DEAD;
                end
            end
        end

        // Decimal run: value times ten plus digit.
        ph = b_ctl.phase[nls_pkg::I_DEC];
        if (ph == nls_pkg::PH_FIRST || ph == nls_pkg::PH_RUN) begin
            if (d <= 5'd9 || d == nls_pkg::SEP_CODE) begin
                if (d <= 5'd9) begin
                    stp_val[nls_pkg::I_DEC] = {b_val[nls_pkg::I_DEC][28:0], 3'b000}
                                            + {b_val[nls_pkg::I_DEC][30:0], 1'b0}
                                            + 32'(d);
                end
                stp_ctl.phase[nls_pkg::I_DEC] = nls_pkg::PH_RUN;
                stp_len[nls_pkg::I_DEC]       = pos_inc;
                used_vec[nls_pkg::I_DEC]      = 1'b1;
            end else begin
                stp_ctl.phase[nls_pkg::I_DEC] = (ph == nls_pkg::PH_RUN) ? nls_pkg::PH_DONE
                                                                        : nls_pkg::PH_DEAD;
            end
        end

        // Hex run: either a 0x prefix or an H suffix.
        ph = b_ctl.phase[nls_pkg::I_HEX];
        if (ph == nls_pkg::PH_FIRST) begin
            if (d <= 5'd9 || d == nls_pkg::SEP_CODE) begin
                if (d <= 5'd9) begin
                    stp_val[nls_pkg::I_HEX] = {b_val[nls_pkg::I_HEX][27:0], d[3:0]};
                end
                stp_ctl.phase[nls_pkg::I_HEX] = (ch == nls_pkg::CH_ZERO) ? nls_pkg::PH_ZERO
                                                                         : nls_pkg::PH_RUN;
                used_vec[nls_pkg::I_HEX] = 1'b1;
            end else begin
                stp_ctl.phase[nls_pkg::I_HEX] = nls_pkg::PH_DEAD;
            end
        end else if (ph == nls_pkg::PH_ZERO && (ch == nls_pkg::CH_UPPER_X
                     || ch == (nls_pkg::CH_UPPER_X | nls_pkg::CASE_BIT))) begin
            stp_ctl.hex_pfx               = 1'b1;
            stp_ctl.phase[nls_pkg::I_HEX] = nls_pkg::PH_RUN;
            stp_len[nls_pkg::I_HEX]       = pos_inc;
            stp_val[nls_pkg::I_HEX]       = '0;
            used_vec[nls_pkg::I_HEX]      = 1'b1;
        end else if (ph == nls_pkg::PH_ZERO || ph == nls_pkg::PH_RUN) begin
            stp_ctl.phase[nls_pkg::I_HEX] = nls_pkg::PH_RUN;
            if (d <= nls_pkg::SEP_CODE) begin
                if (d < nls_pkg::SEP_CODE) begin
                    stp_val[nls_pkg::I_HEX] = {b_val[nls_pkg::I_HEX][27:0], d[3:0]};
                end
                if (b_ctl.hex_pfx) begin
                    stp_len[nls_pkg::I_HEX] = pos_inc;
                end
                used_vec[nls_pkg::I_HEX] = 1'b1;
            end else if (!b_ctl.hex_pfx && (ch == nls_pkg::CH_UPPER_H
                         || ch == (nls_pkg::CH_UPPER_H | nls_pkg::CASE_BIT))) begin
                stp_ctl.phase[nls_pkg::I_HEX] = nls_pkg::PH_DONE;
                stp_len[nls_pkg::I_HEX]       = pos_inc;
                used_vec[nls_pkg::I_HEX]      = 1'b1;
            end else begin
                stp_ctl.phase[nls_pkg::I_HEX] = b_ctl.hex_pfx ? nls_pkg::PH_DONE
                                                              : nls_pkg::PH_DEAD;
            end
        end
    end

    // Pick the strictly longest finished interpretation.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            elen[k] = (!used && stp_ctl.phase[k] == nls_pkg::PH_DONE) ? stp_len[k] : '0;
        end
        for (int k = 0; k < 4; k++) begin
            best[k] = 1'b1;
            for (int j = 0; j < 4; j++) begin
                if (j != k && elen[j] >= elen[k]) begin
                    best[k] = 1'b0;
                end
            end
        end
        found   = |best;
        win_len = '0;
        win_val = '0;
        for (int k = 0; k < 4; k++) begin
            if (best[k]) begin
                win_len = elen[k];
                win_val = stp_val[k];
            end
        end
    end

    // The scan ends when no interpretation takes the character or the limit is hit.
    assign used = |used_vec;
    assign last = used && (b_pos == POS_W'(MAX_LEN - 1));

    always_comb begin
        res.value    = found ? (b_ctl.neg ? (32'd0 - win_val) : win_val) : '0;
        res.length   = 7'(win_len);
        res.found    = found;
        res.too_long = used;
        emit         = 1'b0;
        if (is_sign) begin
            ctl_next     = b_ctl;
            ctl_next.neg = (ch == nls_pkg::CH_MINUS);
            pos_next     = POS_W'(1);
            len_next     = b_len;
            val_next     = b_val;
        end else if (!b_ctl.active) begin
            ctl_next = b_ctl;
            pos_next = b_pos;
            len_next = b_len;
            val_next = b_val;
        end else if (!used || last) begin
            emit     = 1'b1;
            ctl_next = '0;
            pos_next = '0;
            len_next = '0;
            val_next = '0;
        end else begin
            ctl_next = stp_ctl;
            pos_next = pos_inc;
            len_next = stp_len;
            val_next = stp_val;
        end
    end

endmodule

// ----- rtl/core/numeric_literal_scanner.sv -----
// Numeric literal scanner takes one character word per cycle and returns at most one result
// word per character. The scan state is updated in a single pass of logic at each accepted
// word, so the block sustains one character per clock while s_ready is high; the result
// of the character that ends a scan goes to the output register or skid stage. Results pass
// through an output register backed by a one-word skid stage, so s_ready drops only while both
// hold words that the consumer has not taken. There is no configuration and no clearing pass.
// Depends on nls_pkg, nls_step and numeric_literal_scanner_assert.svh.
`include "numeric_literal_scanner_assert.svh"

module numeric_literal_scanner #(
    parameter int MAX_LEN = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_ch,
    input  logic               s_start_req,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_value,
    output logic [6:0]         m_length,
    output logic               m_found,
    output logic               m_too_long
);

    localparam int POS_W = $clog2(MAX_LEN + 1);

    nls_pkg::scan_ctl_t       ctl_reg, ctl_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [3:0][POS_W-1:0]    len_reg, len_next;
    logic [3:0][31:0]         val_reg, val_next;

    logic                     emit;
    nls_pkg::res_t            res;
    nls_pkg::res_t            out_reg;
    nls_pkg::res_t            skid_reg;
    logic                     m_valid_reg;
    logic                     skid_valid_reg;
    logic                     s_fire;
    logic                     out_load;
    logic                     produce;

    assign s_ready  = !skid_valid_reg;
    assign s_fire   = s_valid && s_ready;
    assign out_load = !m_valid_reg || m_ready;
    assign produce  = s_fire && emit;

    // Per-character scan logic.
    nls_step #(
        .MAX_LEN (MAX_LEN),
        .POS_W   (POS_W)
    ) u_step (
        .ch        (s_ch),
        .start_req (s_start_req),
        .ctl       (ctl_reg),
        .pos       (pos_reg),
        .len       (len_reg),
        .val       (val_reg),
        .ctl_next  (ctl_next),
        .pos_next  (pos_next),
        .len_next  (len_next),
        .val_next  (val_next),
        .emit      (emit),
        .res       (res)
    );

    // Scan state advances on every accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
            pos_reg <= '0;
            len_reg <= '0;
            val_reg <= '0;
        end else if (s_fire) begin
            ctl_reg <= ctl_next;
            pos_reg <= pos_next;
            len_reg <= len_next;
            val_reg <= val_next;
        end
    end

    // Output register and skid stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_load) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= produce;
            end
        end else if (produce) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Result payload moves without reset.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (produce) begin
                out_reg <= res;
            end
        end else if (produce) begin
            skid_reg <= res;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_value    = out_reg.value;
    assign m_length   = out_reg.length;
    assign m_found    = out_reg.found;
    assign m_too_long = out_reg.too_long;

    // Checks on the scan state and the output stage.
    `NLS_ASSERT_IMP(a_skid_behind_out, aclk, aresetn, skid_valid_reg, m_valid_reg, "skid word without output word")
    `NLS_ASSERT_IMP(a_found_not_cut, aclk, aresetn, m_valid_reg && m_found, !m_too_long, "result both found and cut off")
    `NLS_ASSERT_IMP(a_idle_pos_zero, aclk, aresetn, !ctl_reg.active, pos_reg == '0, "idle scanner holds a nonzero position")
    `NLS_ASSERT_NXT(a_sign_start, aclk, aresetn, s_fire && s_start_req && (s_ch == nls_pkg::CH_MINUS || s_ch == nls_pkg::CH_PLUS), ctl_reg.active && pos_reg == POS_W'(1), "sign start did not open a scan at position one")

endmodule
